>>> rtl/scfl_pkg.sv
// ----------------------------------------------------------------------------
// scfl_pkg
// Shared types, codes and default sizes for the size-class slot allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package scfl_pkg;

   localparam int unsigned OP_W        = 2;
   localparam int unsigned ITEM_SIZE_W = 7;
   localparam int unsigned SLOT_ADDR_W = 8;
   localparam int unsigned GRANT_W     = 8;
   localparam int unsigned STATUS_W    = 2;

   localparam int unsigned MIN_ITEM_BYTES      = 8;
   localparam int unsigned MAX_ITEM_BYTES_DEF  = 64;
   localparam int unsigned SLOTS_PER_BLOCK_DEF = 32;
   localparam int unsigned MAX_BLOCKS_DEF      = 8;

   typedef enum logic [OP_W-1:0] {
      OP_ALLOC   = 2'd0,
      OP_FREE    = 2'd1,
      OP_RELEASE = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_OOM       = 2'd1,
      ST_BAD_SIZE  = 2'd2,
      ST_NULL_FREE = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOOKUP,
      S_SWEEP,
      S_FETCH,
      S_POP
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic       capture;
      logic       open_start;
      logic       sweep_step;
      logic       link_read;
      logic       read_work;
      logic       free_write;
      logic       pop_write;
      logic       release_one;
      logic       release_all;
      logic       load_rsp;
      logic       grant_en;
      status_type rsp_status;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      op_type op;
      logic   size_ok;
      logic   size_zero;
      logic   is_null;
      logic   addr_ok;
      logic   head_empty;
      logic   blocks_full;
      logic   sweep_last;
   } stat_type;

endpackage

`default_nettype wire

>>> rtl/scfl_ctrl.sv
// ----------------------------------------------------------------------------
// scfl_ctrl
// Sequencer for the allocator: request decode, block threading sweep,
// list pop and result register handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module scfl_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   input  wire scfl_pkg::stat_type stat,
   output scfl_pkg::cmd_type       cmd
);

   scfl_pkg::state_type state_ff;
   scfl_pkg::state_type state_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                out_free;
   logic                is_alloc;

   // the result register can take a word this cycle
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign is_alloc  = (stat.op == scfl_pkg::OP_ALLOC) && stat.size_ok;
   assign req_stall = (state_ff != scfl_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         scfl_pkg::S_IDLE: begin
            if (req_valid) state_in = scfl_pkg::S_LOOKUP;
         end
         scfl_pkg::S_LOOKUP: begin
            if (is_alloc && !stat.head_empty) begin
               state_in = scfl_pkg::S_POP;
            end else if (is_alloc && !stat.blocks_full) begin
               state_in = scfl_pkg::S_SWEEP;
            end else if (out_free) begin
               state_in = scfl_pkg::S_IDLE;
            end
         end
         scfl_pkg::S_SWEEP: begin
            if (stat.sweep_last) state_in = scfl_pkg::S_FETCH;
         end
         scfl_pkg::S_FETCH: begin
            state_in = scfl_pkg::S_POP;
         end
         scfl_pkg::S_POP: begin
            if (out_free) state_in = scfl_pkg::S_IDLE;
         end
         default: begin
            state_in = scfl_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd            = '0;
      cmd.rsp_status = scfl_pkg::ST_OK;
      unique case (state_ff)
         scfl_pkg::S_IDLE: begin
            cmd.capture = req_valid;
         end
         scfl_pkg::S_LOOKUP: begin
            if (is_alloc && !stat.head_empty) begin
               cmd.link_read = 1'b1;
            end else if (is_alloc && !stat.blocks_full) begin
               cmd.open_start = 1'b1;
            end else if (out_free) begin
               cmd.load_rsp = 1'b1;
               unique case (stat.op)
                  scfl_pkg::OP_ALLOC: begin
                     cmd.rsp_status = stat.size_ok ? scfl_pkg::ST_OOM
                                                   : scfl_pkg::ST_BAD_SIZE;
                  end
                  scfl_pkg::OP_FREE: begin
                     if (!stat.size_ok) begin
                        cmd.rsp_status = scfl_pkg::ST_BAD_SIZE;
                     end else if (stat.is_null) begin
                        cmd.rsp_status = scfl_pkg::ST_NULL_FREE;
                     end else begin
                        cmd.free_write = stat.addr_ok;
                     end
                  end
                  scfl_pkg::OP_RELEASE: begin
                     if (stat.size_zero) begin
                        cmd.release_all = 1'b1;
                     end else if (stat.size_ok) begin
                        cmd.release_one = 1'b1;
                     end else begin
                        cmd.rsp_status = scfl_pkg::ST_BAD_SIZE;
                     end
                  end
                  default: begin
                     cmd.rsp_status = scfl_pkg::ST_OK;
                  end
               endcase
            end
         end
         scfl_pkg::S_SWEEP: begin
            cmd.sweep_step = 1'b1;
         end
         scfl_pkg::S_FETCH: begin
            cmd.link_read = 1'b1;
            cmd.read_work = 1'b1;
         end
         scfl_pkg::S_POP: begin
            if (out_free) begin
               cmd.pop_write = 1'b1;
               cmd.load_rsp  = 1'b1;
               cmd.grant_en  = 1'b1;
            end
         end
         default: begin
            cmd.capture = 1'b0;
         end
      endcase
   end

   assign rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= scfl_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef ASSERT_OFF
   a_accept_to_lookup: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == scfl_pkg::S_LOOKUP))
      else $error("accepted word did not move to lookup");

   a_sweep_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == scfl_pkg::S_SWEEP) |=>
         (state_ff == scfl_pkg::S_SWEEP || state_ff == scfl_pkg::S_FETCH))
      else $error("threading sweep left to wrong state");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register overwritten while stalled");
`endif

endmodule

`default_nettype wire

>>> rtl/scfl_dpath.sv
// ----------------------------------------------------------------------------
// scfl_dpath
// Allocator datapath: request registers, per-class head and block count
// memory with valid bits, slot link memory, threading counter, result word.
// ----------------------------------------------------------------------------
`default_nettype none

module scfl_dpath #(
   parameter int unsigned MAX_ITEM_BYTES  = scfl_pkg::MAX_ITEM_BYTES_DEF,
   parameter int unsigned SLOTS_PER_BLOCK = scfl_pkg::SLOTS_PER_BLOCK_DEF,
   parameter int unsigned MAX_BLOCKS      = scfl_pkg::MAX_BLOCKS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic [scfl_pkg::OP_W-1:0]          req_operation,
   input  wire logic [scfl_pkg::ITEM_SIZE_W-1:0]   req_item_size,
   input  wire logic [scfl_pkg::SLOT_ADDR_W-1:0]   req_slot_address,
   input  wire logic                               req_address_is_null,
   input  wire scfl_pkg::cmd_type                  cmd,
   output scfl_pkg::stat_type                      stat,
   output logic [scfl_pkg::GRANT_W-1:0]            rsp_granted_slot,
   output logic [scfl_pkg::STATUS_W-1:0]           rsp_status
);

   localparam int unsigned NUM_CLASSES = MAX_ITEM_BYTES;
   localparam int unsigned CLASS_SLOTS = MAX_BLOCKS * SLOTS_PER_BLOCK;
   localparam int unsigned CW          = $clog2(NUM_CLASSES);
   localparam int unsigned SW          = $clog2(CLASS_SLOTS);
   localparam int unsigned HW          = $clog2(CLASS_SLOTS + 1);
   localparam int unsigned BW          = $clog2(MAX_BLOCKS + 1);
   localparam int unsigned CNTW        = $clog2(SLOTS_PER_BLOCK);
   localparam int unsigned CLS_DEPTH   = 2 ** CW;
   localparam int unsigned LINK_AW     = CW + SW;
   localparam int unsigned LINK_DEPTH  = 2 ** LINK_AW;
   localparam logic [HW-1:0] EMPTY     = HW'(CLASS_SLOTS);

   // request word
   scfl_pkg::op_type                  op_ff;
   logic [scfl_pkg::ITEM_SIZE_W-1:0]  size_ff;
   logic [scfl_pkg::SLOT_ADDR_W-1:0]  addr_ff;
   logic                              null_ff;
   logic [CW-1:0]                     cls_ff;
   logic [CW-1:0]                     req_cls;
   logic [31:0]                       size_ext;

   // class table: {blocks opened, list head}
   logic [BW+HW-1:0]                  cls_mem [CLS_DEPTH];
   logic [BW+HW-1:0]                  cls_rd_ff;
   logic                              cls_vld_ff;
   logic [CLS_DEPTH-1:0]              valid_ff;
   logic                              cls_we;
   logic [BW+HW-1:0]                  cls_wdata;
   logic [HW-1:0]                     head_eff;
   logic [BW-1:0]                     blocks_eff;

   // slot links
   logic [HW-1:0]                     link_mem [LINK_DEPTH];
   logic [HW-1:0]                     link_rd_ff;
   logic [LINK_AW-1:0]                link_raddr;
   logic [LINK_AW-1:0]                link_waddr;
   logic [HW-1:0]                     link_wdata;
   logic                              link_we;

   // work registers
   logic [HW-1:0]                     head_ff;
   logic [BW-1:0]                     blocks_ff;
   logic [SW-1:0]                     sweep_ff;
   logic [CNTW-1:0]                   cnt_ff;
   logic [SW-1:0]                     base_in;

   assign size_ext = 32'(size_ff);
   assign req_cls  = CW'(32'(req_item_size) - 32'd1);

   // a class never written since reset or release reads as empty
   assign head_eff   = cls_vld_ff ? cls_rd_ff[HW-1:0] : EMPTY;
   assign blocks_eff = cls_vld_ff ? cls_rd_ff[HW +: BW] : '0;
   assign base_in    = SW'(32'(blocks_eff) * 32'(SLOTS_PER_BLOCK));

   assign stat.op          = op_ff;
   assign stat.size_ok     = (size_ext >= 32'(scfl_pkg::MIN_ITEM_BYTES)) &&
                             (size_ext <= 32'(MAX_ITEM_BYTES));
   assign stat.size_zero   = (size_ff == '0);
   assign stat.is_null     = null_ff;
   assign stat.addr_ok     = (32'(addr_ff) < 32'(CLASS_SLOTS));
   assign stat.head_empty  = (head_eff >= EMPTY);
   assign stat.blocks_full = (32'(blocks_eff) >= 32'(MAX_BLOCKS));
   assign stat.sweep_last  = (cnt_ff == CNTW'(SLOTS_PER_BLOCK - 1));

   assign link_raddr = {cls_ff, cmd.read_work ? SW'(head_ff) : SW'(head_eff)};
   assign link_we    = cmd.sweep_step || cmd.free_write;

   always_comb begin
      if (cmd.sweep_step) begin
         link_waddr = {cls_ff, sweep_ff};
         link_wdata = stat.sweep_last ? EMPTY : HW'(32'(sweep_ff) + 32'd1);
      end else begin
         link_waddr = {cls_ff, SW'(addr_ff)};
         link_wdata = head_eff;
      end
   end

   assign cls_we    = cmd.free_write || cmd.pop_write;
   assign cls_wdata = cmd.free_write ? {blocks_eff, HW'(addr_ff)}
                                     : {blocks_ff, link_rd_ff};

   always_ff @(posedge clock) begin
      if (link_we) link_mem[link_waddr] <= link_wdata;
      if (cmd.link_read) link_rd_ff <= link_mem[link_raddr];
   end

   always_ff @(posedge clock) begin
      if (cls_we) cls_mem[cls_ff] <= cls_wdata;
      if (cmd.capture) begin
         cls_rd_ff  <= cls_mem[req_cls];
         cls_vld_ff <= valid_ff[req_cls];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.release_all) begin
         valid_ff <= '0;
      end else if (cmd.release_one) begin
         valid_ff[cls_ff] <= 1'b0;
      end else if (cls_we) begin
         valid_ff[cls_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= scfl_pkg::op_type'(req_operation);
         size_ff <= req_item_size;
         addr_ff <= req_slot_address;
         null_ff <= req_address_is_null;
         cls_ff  <= req_cls;
      end
      if (cmd.link_read && !cmd.read_work) begin
         head_ff   <= head_eff;
         blocks_ff <= blocks_eff;
      end
      if (cmd.open_start) begin
         // new block: head at its first slot, links threaded by the sweep
         head_ff   <= HW'(base_in);
         blocks_ff <= blocks_eff + BW'(1);
         sweep_ff  <= base_in;
         cnt_ff    <= '0;
      end
      if (cmd.sweep_step) begin
         sweep_ff <= sweep_ff + SW'(1);
         cnt_ff   <= cnt_ff + CNTW'(1);
      end
      if (cmd.load_rsp) begin
         rsp_granted_slot <= cmd.grant_en ? scfl_pkg::GRANT_W'(head_ff) : '0;
         rsp_status       <= cmd.rsp_status;
      end
   end

`ifndef ASSERT_OFF
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop_write |-> (head_ff < EMPTY))
      else $error("pop from an empty list");

   a_sweep_range: assert property (@(posedge clock) disable iff (reset)
      cmd.sweep_step |-> (32'(sweep_ff) < 32'(CLASS_SLOTS)))
      else $error("threading sweep beyond class slots");

   a_open_room: assert property (@(posedge clock) disable iff (reset)
      cmd.open_start |-> !stat.blocks_full)
      else $error("block opened with every block in use");
`endif

endmodule

`default_nettype wire

>>> rtl/size_class_free_list_allocator_top.sv
// ----------------------------------------------------------------------------
// size_class_free_list_allocator_top
// Slot allocator with one LIFO free list per item size. Requests are taken
// one at a time: free, release and rejected requests answer from lookup,
// an allocate from a non-empty list goes on to a pop, and an allocate that
// opens a new block runs a sweep and a fetch before the pop, since the block's
// slots are threaded into the link memory one entry per cycle through its
// single write port. A finished result waits in an output register, so the
// next request is accepted while it is still stalled. No clearing pass is
// needed after reset: class heads and block counts sit behind valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module size_class_free_list_allocator_top #(
   parameter int unsigned MAX_ITEM_BYTES  = scfl_pkg::MAX_ITEM_BYTES_DEF,
   parameter int unsigned SLOTS_PER_BLOCK = scfl_pkg::SLOTS_PER_BLOCK_DEF,
   parameter int unsigned MAX_BLOCKS      = scfl_pkg::MAX_BLOCKS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [scfl_pkg::OP_W-1:0]          req_operation,
   input  wire logic [scfl_pkg::ITEM_SIZE_W-1:0]   req_item_size,
   input  wire logic [scfl_pkg::SLOT_ADDR_W-1:0]   req_slot_address,
   input  wire logic                               req_address_is_null,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [scfl_pkg::GRANT_W-1:0]            rsp_granted_slot,
   output logic [scfl_pkg::STATUS_W-1:0]           rsp_status
);

   scfl_pkg::cmd_type  cmd;
   scfl_pkg::stat_type stat;

   scfl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   scfl_dpath #(
      .MAX_ITEM_BYTES  (MAX_ITEM_BYTES),
      .SLOTS_PER_BLOCK (SLOTS_PER_BLOCK),
      .MAX_BLOCKS      (MAX_BLOCKS)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .req_operation       (req_operation),
      .req_item_size       (req_item_size),
      .req_slot_address    (req_slot_address),
      .req_address_is_null (req_address_is_null),
      .cmd                 (cmd),
      .stat                (stat),
      .rsp_granted_slot    (rsp_granted_slot),
      .rsp_status          (rsp_status)
   );

endmodule

`default_nettype wire

>>> tb/size_class_free_list_allocator_checker.sv
// ----------------------------------------------------------------------------
// size_class_free_list_allocator_checker
// Watches the request and response channels of the slot allocator. Every
// accepted request is run through a model of the per-class free lists, and
// every accepted response is compared field by field with the oldest
// prediction still waiting.
// ----------------------------------------------------------------------------
module size_class_free_list_allocator_checker
   import scfl_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic [OP_W-1:0]          req_operation,
   input  logic [ITEM_SIZE_W-1:0]   req_item_size,
   input  logic [SLOT_ADDR_W-1:0]   req_slot_address,
   input  logic                     req_address_is_null,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic [GRANT_W-1:0]       rsp_granted_slot,
   input  logic [STATUS_W-1:0]      rsp_status,
   output int unsigned              mismatch_count,
   output int unsigned              pending,
   output int unsigned              request_count,
   output int unsigned              grant_count,
   output int unsigned              oom_count,
   output int unsigned              reject_count
);

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CLASSES     = MAX_ITEM_BYTES_DEF;
   localparam int unsigned PER_BLOCK   = SLOTS_PER_BLOCK_DEF;
   localparam int unsigned BLOCKS      = MAX_BLOCKS_DEF;
   localparam int unsigned CLASS_SLOTS = PER_BLOCK * BLOCKS;
   localparam int unsigned LINK_W      = $clog2(CLASS_SLOTS + 1);
   localparam logic [LINK_W-1:0] EMPTY = LINK_W'(CLASS_SLOTS);

   typedef struct packed {
      logic [GRANT_W-1:0] slot;
      status_type         status;
   } grant_word;

   logic [LINK_W-1:0] link_mem [CLASSES][CLASS_SLOTS];
   logic [LINK_W-1:0] class_head [CLASSES];
   logic [3:0]        blocks_open [CLASSES];

   grant_word   expected_grants [$];
   int unsigned faults = 0;

   initial begin
      mismatch_count = 0;
      pending        = 0;
      request_count  = 0;
      grant_count    = 0;
      oom_count      = 0;
      reject_count   = 0;
   end

   function automatic void clear_class(input int unsigned cls);
      class_head[cls]  = EMPTY;
      blocks_open[cls] = '0;
   endfunction

   function automatic grant_word predict_grant(input op_type op,
                                               input logic [ITEM_SIZE_W-1:0] size,
                                               input logic [SLOT_ADDR_W-1:0] slot,
                                               input logic is_null);
      grant_word   res;
      int unsigned cls;
      int unsigned base;
      logic        size_ok;
      res.slot   = '0;
      res.status = ST_OK;
      size_ok    = size >= MIN_ITEM_BYTES && size <= CLASSES;
      cls        = (size == 0) ? 0 : size - 1;
      case (op)
         OP_ALLOC: begin
            if (!size_ok) begin
               res.status = ST_BAD_SIZE;
            end else begin
               // empty list: thread the next block in ascending order
               if (class_head[cls] == EMPTY && blocks_open[cls] < BLOCKS) begin
                  base = blocks_open[cls] * PER_BLOCK;
                  for (int unsigned i = 0; i + 1 < PER_BLOCK; i++)
                     link_mem[cls][base + i] = LINK_W'(base + i + 1);
                  link_mem[cls][base + PER_BLOCK - 1] = EMPTY;
                  class_head[cls]  = LINK_W'(base);
                  blocks_open[cls] = blocks_open[cls] + 1'b1;
               end
               if (class_head[cls] == EMPTY) begin
                  res.status = ST_OOM;
               end else begin
                  res.slot        = class_head[cls][GRANT_W-1:0];
                  class_head[cls] = link_mem[cls][class_head[cls]];
               end
            end
         end
         OP_FREE: begin
            if (!size_ok) begin
               res.status = ST_BAD_SIZE;
            end else if (is_null) begin
               res.status = ST_NULL_FREE;
            end else if (slot < CLASS_SLOTS) begin
               link_mem[cls][slot] = class_head[cls];
               class_head[cls]     = LINK_W'(slot);
            end
         end
         OP_RELEASE: begin
            if (size == 0) begin
               for (int unsigned c = 0; c < CLASSES; c++)
                  clear_class(c);
            end else if (size_ok) begin
               clear_class(cls);
            end else begin
               res.status = ST_BAD_SIZE;
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      grant_word want;
      if (reset) begin
         for (int unsigned c = 0; c < CLASSES; c++)
            clear_class(c);
         expected_grants.delete();
      end else begin
         // responses first: one leaving in this cycle belongs to an older request
         if (rsp_valid && !rsp_stall) begin
            if (expected_grants.size() == 0) begin
               faults++;
               if (faults <= 10)
                  $display("%t: unexpected word: slot %0d status %0d", $realtime,
                           rsp_granted_slot, rsp_status);
            end else begin
               want = expected_grants.pop_front();
               if (rsp_granted_slot !== want.slot || rsp_status !== want.status) begin
                  faults++;
                  if (faults <= 10)
                     $display("%t: mismatch: slot exp %0d got %0d, status exp %0d got %0d",
                              $realtime, want.slot, rsp_granted_slot, want.status,
                              rsp_status);
               end
            end
            case (rsp_status)
               ST_OK:   grant_count <= grant_count + 1;
               ST_OOM:  oom_count <= oom_count + 1;
               default: reject_count <= reject_count + 1;
            endcase
         end
         if (req_valid && !req_stall) begin
            expected_grants.push_back(predict_grant(op_type'(req_operation), req_item_size,
                                                    req_slot_address, req_address_is_null));
            request_count <= request_count + 1;
         end
      end
      mismatch_count <= faults;
      pending        <= expected_grants.size();
   end

endmodule

>>> tb/tb_size_class_free_list_allocator_top.sv
// ----------------------------------------------------------------------------
// tb_size_class_free_list_allocator_top
// Drives the slot allocator with a directed opening and then random bursts:
// allocate/free traffic on a few busy classes, fills that run a class out of
// memory, malformed and null requests, and releases. Both sides idle at
// random, and the receiver once holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module tb_size_class_free_list_allocator_top;

   timeunit 1ns;
   timeprecision 1ps;

   import scfl_pkg::*;

   localparam int unsigned CLASS_SLOTS    = SLOTS_PER_BLOCK_DEF * MAX_BLOCKS_DEF;
   localparam int unsigned RANDOM_ITEMS   = 1200;
   localparam int unsigned HOLD_CYCLES    = 300;
   localparam int unsigned SETTLE_CYCLES  = SLOTS_PER_BLOCK_DEF + 16;
   localparam int unsigned WATCHDOG_LIMIT = 3000;

   logic                   clock               = 1'b0;
   logic                   reset               = 1'b1;
   logic                   req_valid           = 1'b0;
   logic                   req_stall;
   logic [OP_W-1:0]        req_operation       = OP_ALLOC;
   logic [ITEM_SIZE_W-1:0] req_item_size       = '0;
   logic [SLOT_ADDR_W-1:0] req_slot_address    = '0;
   logic                   req_address_is_null = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall           = 1'b0;
   logic [GRANT_W-1:0]     rsp_granted_slot;
   logic [STATUS_W-1:0]    rsp_status;

   int unsigned mismatch_count;
   int unsigned pending;
   int unsigned request_count;
   int unsigned grant_count;
   int unsigned oom_count;
   int unsigned reject_count;

   int unsigned work_items  = 0;
   int unsigned quiet_count = 0;
   int unsigned hold_left   = 0;
   bit          hold_done   = 1'b0;
   logic        calm;

   // no idling on either side through the middle of the run
   assign calm = work_items >= 500 && work_items < 750;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   size_class_free_list_allocator_top dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_operation       (req_operation),
      .req_item_size       (req_item_size),
      .req_slot_address    (req_slot_address),
      .req_address_is_null (req_address_is_null),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_granted_slot    (rsp_granted_slot),
      .rsp_status          (rsp_status)
   );

   size_class_free_list_allocator_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_operation       (req_operation),
      .req_item_size       (req_item_size),
      .req_slot_address    (req_slot_address),
      .req_address_is_null (req_address_is_null),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_granted_slot    (rsp_granted_slot),
      .rsp_status          (rsp_status),
      .mismatch_count      (mismatch_count),
      .pending             (pending),
      .request_count       (request_count),
      .grant_count         (grant_count),
      .oom_count           (oom_count),
      .reject_count        (reject_count)
   );

   // receiver: random stalls, plus one long hold-off while requests keep coming
   always @(negedge clock) begin
      if (!hold_done && work_items >= 300) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !reset && !calm && $urandom_range(99) < 9;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_count <= 0;
      end else if (quiet_count >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_count <= quiet_count + 1;
      end
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_word(input op_type op, input logic [ITEM_SIZE_W-1:0] size,
                            input logic [SLOT_ADDR_W-1:0] slot, input logic is_null);
      while (!calm && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid           <= 1'b1;
      req_operation       <= op;
      req_item_size       <= size;
      req_slot_address    <= slot;
      req_address_is_null <= is_null;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      @(negedge clock);
      if (op != OP_NONE)
         work_items++;
   endtask

   // mostly slots in the first two blocks, where allocations have landed
   function automatic logic [SLOT_ADDR_W-1:0] free_slot();
      return ($urandom_range(99) < 80) ? SLOT_ADDR_W'($urandom_range(63))
                                       : SLOT_ADDR_W'($urandom_range(255));
   endfunction

   function automatic logic [ITEM_SIZE_W-1:0] any_size();
      return ITEM_SIZE_W'($urandom_range(MIN_ITEM_BYTES, MAX_ITEM_BYTES_DEF));
   endfunction

   task automatic run_burst(input logic [ITEM_SIZE_W-1:0] size, input int unsigned count);
      int unsigned roll;
      repeat (count) begin
         roll = $urandom_range(99);
         if (roll < 60)
            send_word(OP_ALLOC, size, SLOT_ADDR_W'($urandom), 1'($urandom));
         else if (roll < 88)
            send_word(OP_FREE, size, free_slot(), 1'b0);
         else if (roll < 95)
            send_word(OP_FREE, size, SLOT_ADDR_W'($urandom), 1'b1);
         else
            send_word(OP_RELEASE, size, SLOT_ADDR_W'($urandom), 1'($urandom));
      end
   endtask

   initial begin
      logic [ITEM_SIZE_W-1:0] hot [4];
      logic [ITEM_SIZE_W-1:0] size;
      int unsigned            roll;
      int unsigned            fills;
      int unsigned            target;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed opening
      send_word(OP_ALLOC, 7'd8, 8'd0, 1'b0);
      send_word(OP_ALLOC, 7'd8, 8'd0, 1'b0);
      send_word(OP_ALLOC, 7'd64, 8'd255, 1'b1);
      send_word(OP_ALLOC, 7'd7, 8'd0, 1'b0);
      send_word(OP_ALLOC, 7'd0, 8'd0, 1'b0);
      send_word(OP_ALLOC, 7'd65, 8'd0, 1'b0);
      send_word(OP_FREE, 7'd127, 8'd0, 1'b0);
      // bad size wins over null
      send_word(OP_FREE, 7'd7, 8'd3, 1'b1);
      send_word(OP_FREE, 7'd8, 8'd0, 1'b1);
      send_word(OP_FREE, 7'd8, 8'd0, 1'b0);
      send_word(OP_FREE, 7'd8, 8'd0, 1'b0);
      send_word(OP_FREE, 7'd8, 8'd255, 1'b0);
      repeat (4) send_word(OP_ALLOC, 7'd8, 8'd0, 1'b0);
      send_word(OP_NONE, 7'd127, 8'd255, 1'b1);
      send_word(OP_NONE, 7'd0, 8'd0, 1'b0);
      send_word(OP_RELEASE, 7'd8, 8'd0, 1'b0);
      send_word(OP_ALLOC, 7'd8, 8'd0, 1'b0);
      send_word(OP_RELEASE, 7'd5, 8'd0, 1'b0);
      send_word(OP_RELEASE, 7'd65, 8'd0, 1'b0);
      send_word(OP_RELEASE, 7'd0, 8'd0, 1'b0);
      send_word(OP_ALLOC, 7'd64, 8'd0, 1'b0);
      send_word(OP_FREE, 7'd64, 8'd170, 1'b0);
      send_word(OP_ALLOC, 7'd64, 8'd85, 1'b1);

      // random bursts
      hot[0] = 7'd8;
      hot[1] = 7'd64;
      hot[2] = any_size();
      hot[3] = any_size();
      fills  = 0;
      target = work_items + RANDOM_ITEMS;
      while (work_items < target) begin
         roll = $urandom_range(99);
         if ((fills == 0 && work_items >= 150) || (roll < 3 && fills < 3)) begin
            size = any_size();
            // start from an empty class so the fill ends out of memory
            send_word(OP_RELEASE, size, SLOT_ADDR_W'($urandom), 1'($urandom));
            repeat (CLASS_SLOTS + $urandom_range(2, 6))
               send_word(OP_ALLOC, size, SLOT_ADDR_W'($urandom), 1'($urandom));
            repeat (3) send_word(OP_FREE, size, free_slot(), 1'b0);
            repeat (4) send_word(OP_ALLOC, size, SLOT_ADDR_W'($urandom), 1'($urandom));
            fills++;
         end else if (roll < 65) begin
            run_burst(hot[$urandom_range(3)], $urandom_range(5, 20));
         end else if (roll < 85) begin
            run_burst(any_size(), $urandom_range(2, 8));
         end else if (roll < 97) begin
            repeat ($urandom_range(1, 5))
               send_word(op_type'(OP_W'($urandom_range(3))),
                         ITEM_SIZE_W'($urandom_range(127)), SLOT_ADDR_W'($urandom),
                         1'($urandom));
         end else begin
            send_word(OP_RELEASE, 7'd0, SLOT_ADDR_W'($urandom), 1'($urandom));
         end
      end
      req_valid <= 1'b0;

      while (pending != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("run covered %0d requests (%0d class fills to exhaustion)", request_count,
               fills);
      $display("responses: %0d ok, %0d out of memory, %0d rejected or ignored",
               grant_count, oom_count, reject_count);
      if (mismatch_count == 0 && pending == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
